### rtl/core/spffp_pkg.sv
// Shared types, constants and the control store of the sparse pattern packer.
`default_nettype none
package spffp_pkg;

	// fixed field widths of the channels
	localparam int KIND_W    = 2;
	localparam int WORD_IN_W = 32;
	localparam int OFS_W     = 15;
	localparam int LEN_OUT_W = 15;
	localparam int FIT_W     = 11;
	localparam int ST_W      = 2;

	// parameter defaults
	localparam int TABLE_DEPTH_DEF   = 16384;
	localparam int PATTERN_DEPTH_DEF = 1024;
	localparam int WORD_WIDTH_DEF    = 32;

	localparam logic [KIND_W-1:0] K_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] K_TRY   = 2'd1;
	localparam logic [KIND_W-1:0] K_PLACE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_COL     = 2'd1;
	localparam logic [ST_W-1:0] ST_OVF     = 2'd2;
	localparam logic [ST_W-1:0] ST_TOOLONG = 2'd3;

	localparam int PC_W = 5;

	// control store addresses
	localparam logic [PC_W-1:0] P_CLR     = 5'd0;
	localparam logic [PC_W-1:0] P_IDLE    = 5'd1;
	localparam logic [PC_W-1:0] P_DISP0   = 5'd2;
	localparam logic [PC_W-1:0] P_DISP1   = 5'd3;
	localparam logic [PC_W-1:0] P_DISP2   = 5'd4;
	localparam logic [PC_W-1:0] P_DROP    = 5'd5;
	localparam logic [PC_W-1:0] P_LOAD    = 5'd6;
	localparam logic [PC_W-1:0] P_LCHK    = 5'd7;
	localparam logic [PC_W-1:0] P_LWR     = 5'd8;
	localparam logic [PC_W-1:0] P_LFULL   = 5'd9;
	localparam logic [PC_W-1:0] P_TRY     = 5'd10;
	localparam logic [PC_W-1:0] P_TLOOP   = 5'd11;
	localparam logic [PC_W-1:0] P_TINNER  = 5'd12;
	localparam logic [PC_W-1:0] P_TCMP    = 5'd13;
	localparam logic [PC_W-1:0] P_TNEXT   = 5'd14;
	localparam logic [PC_W-1:0] P_TFOUND  = 5'd15;
	localparam logic [PC_W-1:0] P_TNOFIT  = 5'd16;
	localparam logic [PC_W-1:0] P_PLACE   = 5'd17;
	localparam logic [PC_W-1:0] P_PINIT   = 5'd18;
	localparam logic [PC_W-1:0] P_PINNER  = 5'd19;
	localparam logic [PC_W-1:0] P_PCMP    = 5'd20;
	localparam logic [PC_W-1:0] P_PCOL    = 5'd21;
	localparam logic [PC_W-1:0] P_POVF    = 5'd22;
	localparam logic [PC_W-1:0] P_PWR     = 5'd23;
	localparam logic [PC_W-1:0] P_PWLOOP  = 5'd24;
	localparam logic [PC_W-1:0] P_PWSTORE = 5'd25;
	localparam logic [PC_W-1:0] P_PDONE   = 5'd26;

	typedef enum logic [3:0] {
		C_NEXT     = 4'd0,
		C_ALWAYS   = 4'd1,
		C_NO_IN    = 4'd2,
		C_K_LOAD   = 4'd3,
		C_K_TRY    = 4'd4,
		C_K_PLACE  = 4'd5,
		C_PFULL    = 4'd6,
		C_OFF_END  = 4'd7,
		C_I_END    = 4'd8,
		C_NOHIT    = 4'd9,
		C_OVF      = 4'd10,
		C_CLR_MORE = 4'd11
	} cond_t;

	typedef enum logic [2:0] {
		R_TOOLONG = 3'd0,
		R_TRY     = 3'd1,
		R_NOFIT   = 3'd2,
		R_PCOL    = 3'd3,
		R_POVF    = 3'd4,
		R_PLACE   = 3'd5
	} res_t;

	typedef struct packed {
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            accept;
		logic            start;
		logic            pwrite;
		logic            off_zero;
		logic            off_poff;
		logic            off_inc;
		logic            i_zero;
		logic            rd;
		logic            twrite;
		logic            tclr;
		logic            emit;
		logic            setlen;
		res_t            res;
	} uword_t;

	typedef struct packed {
		logic no_in;
		logic k_load;
		logic k_try;
		logic k_place;
		logic pfull;
		logic off_end;
		logic i_end;
		logic nohit;
		logic ovf;
		logic clr_more;
		logic out_busy;
	} flags_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '0;
		w.cond = C_NEXT;
		w.target = P_IDLE;
		w.res = R_TOOLONG;
		case (pc)
			P_CLR: begin
				w.tclr = 1'b1;
				w.cond = C_CLR_MORE;
				w.target = P_CLR;
			end
			P_IDLE: begin
				w.accept = 1'b1;
				w.cond = C_NO_IN;
				w.target = P_IDLE;
			end
			P_DISP0: begin
				w.cond = C_K_LOAD;
				w.target = P_LOAD;
			end
			P_DISP1: begin
				w.cond = C_K_TRY;
				w.target = P_TRY;
			end
			P_DISP2: begin
				w.cond = C_K_PLACE;
				w.target = P_PLACE;
			end
			P_DROP: w.cond = C_ALWAYS;
			P_LOAD: w.start = 1'b1;
			P_LCHK: begin
				w.cond = C_PFULL;
				w.target = P_LFULL;
			end
			P_LWR: begin
				w.pwrite = 1'b1;
				w.cond = C_ALWAYS;
			end
			P_LFULL: begin
				w.emit = 1'b1;
				w.res = R_TOOLONG;
				w.cond = C_ALWAYS;
			end
			P_TRY: w.off_zero = 1'b1;
			P_TLOOP: begin
				w.i_zero = 1'b1;
				w.cond = C_OFF_END;
				w.target = P_TNOFIT;
			end
			P_TINNER: begin
				w.rd = 1'b1;
				w.cond = C_I_END;
				w.target = P_TFOUND;
			end
			P_TCMP: begin
				w.cond = C_NOHIT;
				w.target = P_TINNER;
			end
			P_TNEXT: begin
				w.off_inc = 1'b1;
				w.cond = C_ALWAYS;
				w.target = P_TLOOP;
			end
			P_TFOUND: begin
				w.emit = 1'b1;
				w.res = R_TRY;
				w.cond = C_ALWAYS;
			end
			P_TNOFIT: begin
				w.emit = 1'b1;
				w.res = R_NOFIT;
				w.cond = C_ALWAYS;
			end
			P_PLACE: begin
				w.off_poff = 1'b1;
				w.cond = C_OVF;
				w.target = P_POVF;
			end
			P_PINIT: w.i_zero = 1'b1;
			P_PINNER: begin
				w.rd = 1'b1;
				w.cond = C_I_END;
				w.target = P_PWR;
			end
			P_PCMP: begin
				w.cond = C_NOHIT;
				w.target = P_PINNER;
			end
			P_PCOL: begin
				w.emit = 1'b1;
				w.res = R_PCOL;
				w.cond = C_ALWAYS;
			end
			P_POVF: begin
				w.emit = 1'b1;
				w.res = R_POVF;
				w.cond = C_ALWAYS;
			end
			P_PWR: w.i_zero = 1'b1;
			P_PWLOOP: begin
				w.rd = 1'b1;
				w.cond = C_I_END;
				w.target = P_PDONE;
			end
			P_PWSTORE: begin
				w.twrite = 1'b1;
				w.cond = C_ALWAYS;
				w.target = P_PWLOOP;
			end
			P_PDONE: begin
				w.emit = 1'b1;
				w.setlen = 1'b1;
				w.res = R_PLACE;
				w.cond = C_ALWAYS;
			end
			default: w.cond = C_ALWAYS;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

### rtl/core/spffp_if.sv
// Valid/ready channel interfaces for the packer's item and result streams.
`default_nettype none
interface spffp_in_if import spffp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic                 start_pattern;
	logic [WORD_IN_W-1:0] pattern_word;
	logic [OFS_W-1:0]     place_offset;

	modport source(output valid, kind, start_pattern, pattern_word, place_offset,
		input ready);
	modport sink(input valid, kind, start_pattern, pattern_word, place_offset,
		output ready);
endinterface

interface spffp_out_if import spffp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OFS_W-1:0]     found_offset;
	logic [LEN_OUT_W-1:0] new_length;
	logic [FIT_W-1:0]     fit_degree;
	logic [ST_W-1:0]      status;

	modport source(output valid, found_offset, new_length, fit_degree, status,
		input ready);
	modport sink(input valid, found_offset, new_length, fit_degree, status,
		output ready);
endinterface
`default_nettype wire

### rtl/core/spffp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spffp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/spffp_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
`default_nettype none
module spffp_seq import spffp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire flags_t flags,
	output uword_t      uw
);
	logic [PC_W-1:0] pc_q;
	logic            taken;
	logic            hold;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.cond)
			C_NEXT:     taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_NO_IN:    taken = flags.no_in;
			C_K_LOAD:   taken = flags.k_load;
			C_K_TRY:    taken = flags.k_try;
			C_K_PLACE:  taken = flags.k_place;
			C_PFULL:    taken = flags.pfull;
			C_OFF_END:  taken = flags.off_end;
			C_I_END:    taken = flags.i_end;
			C_NOHIT:    taken = flags.nohit;
			C_OVF:      taken = flags.ovf;
			C_CLR_MORE: taken = flags.clr_more;
			default:    taken = 1'b0;
		endcase
	end

	// a result step waits until the output register is free
	assign hold = uw.emit && flags.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_CLR;
		end else if (!hold) begin
			if (taken)
				pc_q <= uw.target;
			else
				pc_q <= pc_q + PC_W'(1);
		end
	end
endmodule
`default_nettype wire

### rtl/core/spffp_dp.sv
// Packer datapath: pattern and table RAMs, offset and index counters, result register.
`default_nettype none
module spffp_dp import spffp_pkg::*; #(
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
	parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
	parameter int WORD_WIDTH    = WORD_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire uword_t               uw,
	output flags_t                    flags,
	input  wire logic                 in_valid,
	input  wire logic [KIND_W-1:0]    in_kind,
	input  wire logic                 in_start,
	input  wire logic [WORD_IN_W-1:0] in_word,
	input  wire logic [OFS_W-1:0]     in_poff,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [OFS_W-1:0]          out_off,
	output logic [LEN_OUT_W-1:0]      out_len,
	output logic [FIT_W-1:0]          out_fit,
	output logic [ST_W-1:0]           out_st
);
	localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
	localparam int PLEN_W = $clog2(PATTERN_DEPTH + 1);
	localparam int TA_W   = $clog2(TABLE_DEPTH);
	localparam int PA_W   = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int MX1_W  = (LEN_W > OFS_W) ? LEN_W : OFS_W;
	localparam int MX2_W  = (MX1_W > PLEN_W) ? MX1_W : PLEN_W;
	localparam int SUM_W  = MX2_W + 1;

	logic [KIND_W-1:0]     kind_q;
	logic                  start_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [OFS_W-1:0]      poff_q;
	logic [LEN_W-1:0]      used_q;
	logic [PLEN_W-1:0]     plen_q;
	logic [SUM_W-1:0]      off_q;
	logic [PLEN_W-1:0]     i_q;
	logic [TA_W-1:0]       taddr_s1;
	logic                  rng_s1;

	logic [WORD_IN_W+WORD_WIDTH-1:0] word_wide;
	logic [SUM_W-1:0]      tsum;
	logic                  t_in_range;
	logic [WORD_WIDTH-1:0] pdata;
	logic [WORD_WIDTH-1:0] tdata;
	logic                  t_we;
	logic [TA_W-1:0]       t_waddr;
	logic [WORD_WIDTH-1:0] t_wdata;
	logic                  out_busy;
	logic                  emit_fire;

	logic [SUM_W-1:0] sz;
	logic [SUM_W-1:0] usedx;
	logic [SUM_W-1:0] offsz;
	logic [SUM_W-1:0] nl;
	logic [SUM_W-1:0] gain;
	logic [SUM_W-1:0] used_sz;
	logic             try_ovf;
	logic [SUM_W-1:0] r_off;
	logic [SUM_W-1:0] r_len;
	logic [SUM_W-1:0] r_fit;
	logic [ST_W-1:0]  r_st;
	logic [SUM_W+OFS_W-1:0]     off_wide;
	logic [SUM_W+LEN_OUT_W-1:0] len_wide;
	logic [SUM_W+FIT_W-1:0]     fit_wide;

	assign word_wide = {{WORD_WIDTH{1'b0}}, in_word};

	// item latch
	always_ff @(posedge clk) begin
		if (uw.accept && in_valid) begin
			kind_q  <= in_kind;
			start_q <= in_start;
			word_q  <= word_wide[WORD_WIDTH-1:0];
			poff_q  <= in_poff;
		end
	end

	assign tsum       = off_q + SUM_W'(i_q);
	assign t_in_range = tsum < SUM_W'(TABLE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			plen_q <= '0;
			off_q  <= '0;
			i_q    <= '0;
		end else begin
			if (uw.start && start_q)
				plen_q <= '0;
			else if (uw.pwrite)
				plen_q <= plen_q + PLEN_W'(1);
			if (uw.off_zero)
				off_q <= '0;
			else if (uw.off_poff)
				off_q <= SUM_W'(poff_q);
			else if (uw.off_inc || uw.tclr)
				off_q <= off_q + SUM_W'(1);
			if (uw.i_zero)
				i_q <= '0;
			else if (uw.rd)
				i_q <= i_q + PLEN_W'(1);
			if (uw.setlen && emit_fire)
				used_q <= nl[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (uw.rd) begin
			taddr_s1 <= tsum[TA_W-1:0];
			rng_s1   <= t_in_range;
		end
	end

	spffp_ram #(.WIDTH(WORD_WIDTH), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
		.clk   (clk),
		.we    (uw.pwrite),
		.waddr (plen_q[PA_W-1:0]),
		.wdata (word_q),
		.re    (uw.rd),
		.raddr (i_q[PA_W-1:0]),
		.rdata (pdata)
	);

	// the clearing pass and the place write share the single write port
	assign t_we    = uw.tclr || (uw.twrite && (pdata != '0));
	assign t_waddr = uw.tclr ? off_q[TA_W-1:0] : taddr_s1;
	assign t_wdata = uw.tclr ? '0 : pdata;

	spffp_ram #(.WIDTH(WORD_WIDTH), .DEPTH(TABLE_DEPTH)) u_tab_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (uw.rd),
		.raddr (tsum[TA_W-1:0]),
		.rdata (tdata)
	);

	// result arithmetic, shared by try and place
	assign sz      = SUM_W'(plen_q);
	assign usedx   = SUM_W'(used_q);
	assign offsz   = off_q + sz;
	assign used_sz = usedx + sz;
	assign try_ovf = offsz > SUM_W'(TABLE_DEPTH);
	assign nl      = (offsz > usedx) ? offsz : usedx;
	assign gain    = (used_sz >= nl) ? used_sz - nl : '0;

	always_comb begin
		r_off = off_q;
		r_len = usedx;
		r_fit = '0;
		r_st  = ST_OK;
		case (uw.res)
			R_TOOLONG: begin
				r_off = '0;
				r_st  = ST_TOOLONG;
			end
			R_TRY: begin
				if (try_ovf) begin
					r_st = ST_OVF;
				end else begin
					r_len = nl;
					r_fit = gain;
				end
			end
			R_NOFIT: begin
				r_off = usedx;
				r_len = used_sz;
			end
			R_PCOL: r_st = ST_COL;
			R_POVF: r_st = ST_OVF;
			R_PLACE: begin
				r_len = nl;
				r_fit = gain;
			end
			default: r_st = ST_OK;
		endcase
	end

	assign off_wide = {{OFS_W{1'b0}}, r_off};
	assign len_wide = {{LEN_OUT_W{1'b0}}, r_len};
	assign fit_wide = {{FIT_W{1'b0}}, r_fit};

	assign out_busy  = out_valid && !out_ready;
	assign emit_fire = uw.emit && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (emit_fire)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_off <= off_wide[OFS_W-1:0];
			out_len <= len_wide[LEN_OUT_W-1:0];
			out_fit <= fit_wide[FIT_W-1:0];
			out_st  <= r_st;
		end
	end

	always_comb begin
		flags.no_in    = !in_valid;
		flags.k_load   = kind_q == K_LOAD;
		flags.k_try    = kind_q == K_TRY;
		flags.k_place  = kind_q == K_PLACE;
		flags.pfull    = plen_q >= PLEN_W'(PATTERN_DEPTH);
		flags.off_end  = off_q > usedx;
		flags.i_end    = i_q == plen_q;
		flags.nohit    = !((pdata != '0) && (tdata != '0) && rng_s1);
		flags.ovf      = (SUM_W'(poff_q) + sz) > SUM_W'(TABLE_DEPTH);
		flags.clr_more = off_q != SUM_W'(TABLE_DEPTH - 1);
		flags.out_busy = out_busy;
	end
endmodule
`default_nettype wire

### rtl/core/sparse_pattern_first_fit_packer_top.sv
// Top level of the first-fit sparse pattern packer: sequencer, datapath, checks.
//
// The packer holds a shared table of TABLE_DEPTH words and one sparse pattern
// loaded a word at a time; a try item reports the first offset at which the
// pattern's nonzero words meet only empty table cells, a place item writes the
// pattern at a given offset. Control runs from a microcode store, so one item is
// handled at a time. After reset the table is swept to zero, one entry a cycle;
// no item is taken meanwhile. A try walks the offsets from zero, comparing the
// pattern word by word, the compare loop being bound by the registered read of
// the two RAMs. A place that succeeds first compares the whole pattern, then
// writes its nonzero words; one refused for a collision ends at the first clash,
// one refused for overflow before any compare. The result sits in an output
// register, so the next item is taken while it waits.
`default_nettype none
module sparse_pattern_first_fit_packer_top import spffp_pkg::*; #(
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
	parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
	parameter int WORD_WIDTH    = WORD_WIDTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	spffp_in_if.sink  item,
	spffp_out_if.source result
);
	uword_t uw;
	flags_t flags;

	spffp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw)
	);

	spffp_dp #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.PATTERN_DEPTH (PATTERN_DEPTH),
		.WORD_WIDTH    (WORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.uw        (uw),
		.flags     (flags),
		.in_valid  (item.valid),
		.in_kind   (item.kind),
		.in_start  (item.start_pattern),
		.in_word   (item.pattern_word),
		.in_poff   (item.place_offset),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_off   (result.found_offset),
		.out_len   (result.new_length),
		.out_fit   (result.fit_degree),
		.out_st    (result.status)
	);

	assign item.ready = uw.accept;

	// no item is taken while the table is being cleared
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		uw.tclr |-> !item.ready)
		else $error("item taken during table clear");

	// a refused or overflowing result never reports a gain
	a_fit_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status != ST_OK)) |-> (result.fit_degree == '0))
		else $error("nonzero fit degree on a failed result");

	// a blocked result step stays put until the output register frees
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.emit && flags.out_busy) |=> uw.emit)
		else $error("sequencer left a result step while output was blocked");

	// a new result is only loaded once the previous transfer is done
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(result.status)))
		else $error("pending result overwritten");
endmodule
`default_nettype wire

### tb/sv/spffp_fit_checker.sv
// Checker for the packer: predicts every result from the accepted items and compares.
module spffp_fit_checker import spffp_pkg::*; #(
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
	parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	spffp_in_if               item,
	spffp_out_if              result,
	output int unsigned       fault_count,
	output int unsigned       results_due,
	output logic [OFS_W-1:0]  first_fit,
	output int unsigned       table_len
);

	typedef struct packed {
		logic [OFS_W-1:0]     offset;
		logic [LEN_OUT_W-1:0] length;
		logic [FIT_W-1:0]     degree;
		logic [ST_W-1:0]      status;
	} fit_result_t;

	logic [WORD_IN_W-1:0] cells [TABLE_DEPTH];
	logic [WORD_IN_W-1:0] pat [PATTERN_DEPTH];
	int unsigned          used_len;
	int unsigned          pat_len;
	fit_result_t          pending_fits [$];

	// cells past the end of the table read as empty
	function automatic bit window_clashes(input int unsigned ofs);
		for (int unsigned i = 0; i < pat_len; i++) begin
			if (pat[i] != '0 && ofs + i < TABLE_DEPTH && cells[ofs + i] != '0)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic fit_result_t make_fit(input int unsigned ofs, input int unsigned len,
		input int unsigned deg, input logic [ST_W-1:0] st);
		fit_result_t r;
		r.offset = OFS_W'(ofs);
		r.length = LEN_OUT_W'(len);
		r.degree = FIT_W'(deg);
		r.status = st;
		return r;
	endfunction

	function automatic void add_fit(input fit_result_t r);
		pending_fits.insert(pending_fits.size(), r);
	endfunction

	task automatic predict_item(input logic [KIND_W-1:0] k, input logic s,
		input logic [WORD_IN_W-1:0] w, input logic [OFS_W-1:0] po);
		int unsigned ofs;
		int unsigned nl;
		int unsigned sz;
		bit          found;
		sz = pat_len;
		case (k)
			K_LOAD: begin
				if (s)
					pat_len = 0;
				if (pat_len >= PATTERN_DEPTH) begin
					add_fit(make_fit(0, used_len, 0, ST_TOOLONG));
				end else begin
					pat[pat_len] = w;
					pat_len++;
				end
			end
			K_TRY: begin
				found = 1'b0;
				ofs = 0;
				while (!found && ofs <= used_len) begin
					if (!window_clashes(ofs))
						found = 1'b1;
					else
						ofs++;
				end
				if (!found) begin
					ofs = used_len;
					add_fit(make_fit(used_len, used_len + sz, 0, ST_OK));
				end else if (ofs + sz > TABLE_DEPTH) begin
					add_fit(make_fit(ofs, used_len, 0, ST_OVF));
				end else begin
					nl = (ofs + sz > used_len) ? ofs + sz : used_len;
					add_fit(make_fit(ofs, nl, used_len + sz - nl, ST_OK));
				end
				first_fit = OFS_W'(ofs);
			end
			K_PLACE: begin
				ofs = po;
				if (ofs + sz > TABLE_DEPTH) begin
					add_fit(make_fit(ofs, used_len, 0, ST_OVF));
				end else if (window_clashes(ofs)) begin
					add_fit(make_fit(ofs, used_len, 0, ST_COL));
				end else begin
					for (int unsigned i = 0; i < sz; i++) begin
						if (pat[i] != '0)
							cells[ofs + i] = pat[i];
					end
					nl = (ofs + sz > used_len) ? ofs + sz : used_len;
					// a gap left before the offset counts as used, so the gain floors at zero
					add_fit(make_fit(ofs, nl,
						(used_len + sz >= nl) ? used_len + sz - nl : 0, ST_OK));
					used_len = nl;
				end
			end
			default: ;
		endcase
	endtask

	task automatic note_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			fault_count++;
		end
	endtask

	task automatic check_fit(input logic [OFS_W-1:0] o, input logic [LEN_OUT_W-1:0] l,
		input logic [FIT_W-1:0] d, input logic [ST_W-1:0] st);
		fit_result_t want;
		if (pending_fits.size() == 0) begin
			$display("%0t: result expected none got offset %0d length %0d degree %0d status %0d",
				$time, o, l, d, st);
			fault_count++;
		end else begin
			want = pending_fits.pop_front();
			note_field("found_offset", 16'(want.offset), 16'(o));
			note_field("new_length", 16'(want.length), 16'(l));
			note_field("fit_degree", 16'(want.degree), 16'(d));
			note_field("status", 16'(want.status), 16'(st));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				cells[i] = '0;
			used_len = 0;
			pat_len = 0;
			pending_fits.delete();
			fault_count = 0;
			first_fit = '0;
		end else begin
			// predict first: a transfer on both channels at one edge never pairs up
			if (item.valid && item.ready)
				predict_item(item.kind, item.start_pattern, item.pattern_word, item.place_offset);
			if (result.valid && result.ready)
				check_fit(result.found_offset, result.new_length, result.fit_degree,
					result.status);
		end
		results_due = pending_fits.size();
		table_len = used_len;
	end

endmodule

### tb/sv/tb_sparse_pattern_first_fit_packer_top.sv
// Testbench top for the packer: clock, reset, item and result stimulus, verdict.
module tb_sparse_pattern_first_fit_packer_top;
	import spffp_pkg::*;

	localparam int unsigned ITEM_TARGET = 650;
	localparam int unsigned IDLE_LIMIT  = 1000000;
	localparam logic [KIND_W-1:0] K_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spffp_in_if  item_ch ();
	spffp_out_if res_ch ();

	int unsigned      fault_count;
	int unsigned      results_due;
	int unsigned      table_len;
	logic [OFS_W-1:0] first_fit;

	bit          calm;
	int unsigned pat_words;
	int unsigned sent;
	int unsigned n_load;
	int unsigned n_try;
	int unsigned n_place;
	int unsigned idle_run;
	int unsigned len;
	int unsigned action;
	int unsigned stall;
	bit          pressure_done;
	logic [WORD_IN_W-1:0] w;

	always #5 clk = ~clk;

	sparse_pattern_first_fit_packer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	spffp_fit_checker fit_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (res_ch),
		.fault_count (fault_count),
		.results_due (results_due),
		.first_fit   (first_fit),
		.table_len   (table_len)
	);

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic push_item(input logic [KIND_W-1:0] k, input logic s,
		input logic [WORD_IN_W-1:0] wd, input logic [OFS_W-1:0] o);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(9, 0);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.start_pattern <= s;
		item_ch.pattern_word <= wd;
		item_ch.place_offset <= o;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		case (k)
			K_LOAD: begin
				n_load++;
				if (s)
					pat_words = 1;
				else if (pat_words < PATTERN_DEPTH_DEF)
					pat_words++;
			end
			K_TRY: n_try++;
			K_PLACE: n_place++;
			default: ;
		endcase
		if (k != K_UNUSED)
			sent++;
	endtask

	task automatic load_word(input logic s, input logic [WORD_IN_W-1:0] wd);
		push_item(K_LOAD, s, wd, OFS_W'($urandom));
	endtask

	task automatic try_fit(input logic s);
		push_item(K_TRY, s, $urandom, OFS_W'($urandom));
	endtask

	task automatic place_at(input logic [OFS_W-1:0] o, input logic s);
		push_item(K_PLACE, s, $urandom, o);
	endtask

	// valid drops first so the last item is not taken again while waiting
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (results_due != 0);
	endtask

	// sparse words: a good share of empty slots, the rest biased to extremes
	function automatic logic [WORD_IN_W-1:0] pick_word();
		case ($urandom_range(7, 0))
			0, 1, 2: return '0;
			3: return '1;
			4: return 32'h0000_0001;
			5: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		res_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(9, 0);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// counts cycles with no transfer on either channel; the clearing sweep counts too
	initial begin
		idle_run = 0;
		while (idle_run < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("tb_sparse_pattern_first_fit_packer_top: FAIL");
		$finish;
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.kind = K_LOAD;
		item_ch.start_pattern = 1'b0;
		item_ch.pattern_word = '0;
		item_ch.place_offset = '0;
		calm = 1'b0;
		pat_words = 0;
		sent = 0;
		n_load = 0;
		n_try = 0;
		n_place = 0;
		pressure_done = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty pattern: try answers zero, place past the used length leaves a gap
		try_fit(1'b0);
		place_at(OFS_W'(3), 1'b0);
		load_word(1'b1, '1);
		load_word(1'b0, '0);
		load_word(1'b0, 32'h0000_0001);
		push_item(K_UNUSED, 1'b1, $urandom, OFS_W'($urandom));
		load_word(1'b0, 32'h8000_0000);
		try_fit(1'b1);
		place_at(first_fit, 1'b1);
		place_at(OFS_W'(0), 1'b0);
		place_at(OFS_W'(16384), 1'b0);
		place_at('1, 1'b0);
		place_at(OFS_W'(16381), 1'b0);
		try_fit(1'b0);
		place_at(OFS_W'(table_len + 1), 1'b0);
		// a pattern of one empty slot fits anywhere and writes nothing
		load_word(1'b1, '0);
		try_fit(1'b0);
		place_at(OFS_W'(0), 1'b0);
		drain_results();

		// load a pattern, then mostly try and place at the offset found
		while (sent < ITEM_TARGET) begin
			if ($urandom_range(19, 0) == 0)
				calm = ~calm;
			len = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
			for (int unsigned j = 0; j < len; j++) begin
				load_word(j == 0 || $urandom_range(29, 0) == 0, pick_word());
				if ($urandom_range(24, 0) == 0)
					push_item(K_UNUSED, 1'($urandom), $urandom, OFS_W'($urandom));
			end
			action = $urandom_range(9, 0);
			if (action <= 6) begin
				try_fit(1'($urandom));
				place_at(first_fit, 1'($urandom));
				if ($urandom_range(3, 0) == 0)
					try_fit(1'($urandom));
			end else if (action == 7) begin
				place_at(OFS_W'($urandom_range(table_len < 3000 ? table_len + 4 : table_len, 0)),
					1'($urandom));
			end else if (action == 8) begin
				place_at(OFS_W'($urandom_range(32767, TABLE_DEPTH_DEF + 1 - pat_words)),
					1'($urandom));
			end else begin
				try_fit(1'($urandom));
			end
			if (!pressure_done && sent >= ITEM_TARGET / 2) begin
				drain_results();
				pressure_done = 1'b1;
			end
		end
		calm = 1'b0;
		drain_results();

		// full pattern, then one word too many
		for (int unsigned j = 0; j < PATTERN_DEPTH_DEF; j++) begin
			w = $urandom;
			if (w == '0)
				w = 32'h0000_0001;
			load_word(j == 0, w);
		end
		load_word(1'b0, $urandom);
		// pack the rest of the table solid so the only fit hangs past its end
		while (table_len + PATTERN_DEPTH_DEF <= TABLE_DEPTH_DEF)
			place_at(OFS_W'(table_len), 1'b0);
		try_fit(1'b0);
		place_at(first_fit, 1'b0);
		place_at(OFS_W'(0), 1'b0);
		push_item(K_UNUSED, 1'b0, $urandom, OFS_W'($urandom));

		drain_results();
		repeat (400) @(negedge clk);
		$display("items: %0d loads, %0d tries, %0d places; used table length %0d",
			n_load, n_try, n_place, table_len);
		$display("covered empty and full patterns, collisions, overflows, search off the end");
		if (fault_count == 0 && results_due == 0)
			$display("tb_sparse_pattern_first_fit_packer_top: PASS");
		else
			$display("tb_sparse_pattern_first_fit_packer_top: FAIL");
		$finish;
	end

endmodule
